// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the duty cycle averager.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define PMDCA_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define PMDCA_NEVER(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/pmdca_pkg.sv
// ----------------------------------------------------------------------------
// pmdca_pkg
// Types, codes and constants shared by the duty cycle averager modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pmdca_pkg;

    localparam int TICK_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int SAMPLE_W   = 16;
    localparam int PM_AVG_W   = 20;
    localparam int HC_AVG_W   = 16;
    localparam int AQI_W      = 9;
    localparam int USED_W     = 6;

    localparam int MAX_SAMPLES_DEF = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_WAKE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP   = 2'd2;

    localparam logic [TICK_W-1:0] WAKE_TICKS_RST    = 20'd15000;
    localparam logic [TICK_W-1:0] CAPTURE_TICKS_RST = 20'd5000;
    localparam logic [TICK_W-1:0] SLEEP_TICKS_RST   = 20'd70000;
    localparam logic [TICK_W-1:0] ELAPSED_MAX       = '1;

    // Phase codes.
    localparam logic [1:0] PH_AWAKE   = 2'd0;
    localparam logic [1:0] PH_CAPTURE = 2'd1;
    localparam logic [1:0] PH_SLEEP   = 2'd2;

    // Sensor command codes.
    localparam logic [1:0] SCMD_NONE    = 2'd0;
    localparam logic [1:0] SCMD_WAKE    = 2'd1;
    localparam logic [1:0] SCMD_TRIGGER = 2'd2;
    localparam logic [1:0] SCMD_SLEEP   = 2'd3;

    // Input command codes.
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // ceil(2^23 / 10): exact division by ten for any 20-bit value.
    localparam logic [19:0] DIV10_MAGIC = 20'd838861;
    localparam int          DIV10_SHIFT = 23;

    typedef struct packed {
        logic step;
        logic div_start;
        logic avg_load;
        logic tens_load;
        logic aqi_start;
        logic aqi_load;
        logic out_load;
    } pmdca_cmd_t;

    typedef struct packed {
        logic cap_end;
        logic cap_empty;
        logic div_done;
    } pmdca_sts_t;

endpackage

`default_nettype wire

// File: rtl/pmdca_divider.sv
// ----------------------------------------------------------------------------
// pmdca_divider
// Restoring shift-subtract divider giving one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pmdca_divider
    import pmdca_pkg::*;
#(
    parameter int NUM_W = 27,
    parameter int DEN_W = 11
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_dif;
    logic             fits;
    logic [DEN_W-1:0] rem_next;
    logic             last;

    always_comb
    begin
        rem_sh   = {rem_reg, quot_reg[NUM_W-1]};
        fits     = (rem_sh >= {1'b0, den_reg});
        rem_dif  = rem_sh - {1'b0, den_reg};
        rem_next = fits ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        last     = (cnt_reg == CNT_W'(NUM_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= num;
            den_reg  <= den;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
            rem_reg  <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

    `PMDCA_NEVER(a_div_start_busy, clk, rst_n, start && busy_reg, "divider restarted while busy")

endmodule

`default_nettype wire

// File: rtl/pmdca_datapath.sv
// ----------------------------------------------------------------------------
// pmdca_datapath
// Phase timing, sample sums, averaging, AQI and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pmdca_datapath
    import pmdca_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]    cfg_data,
    input  wire logic                 cmd,
    input  wire logic [SAMPLE_W-1:0]  pm25_sample,
    input  wire logic [SAMPLE_W-1:0]  hcho_sample,
    input  wire pmdca_cmd_t           ctl,
    output pmdca_sts_t                sts,
    output logic [1:0]                phase,
    output logic [1:0]                sensor_cmd,
    output logic                      reading_done,
    output logic                      no_data,
    output logic [PM_AVG_W-1:0]       pm25_tenths,
    output logic [HC_AVG_W-1:0]       hcho_average,
    output logic [AQI_W-1:0]          aqi,
    output logic [USED_W-1:0]         samples_used
);

    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W     = SAMPLE_W + CNT_W;
    localparam int NUM_W     = SUM_W + 5;
    localparam int DEN_W     = CNT_W + 1;
    localparam int P_W       = PM_AVG_W + 20 - DIV10_SHIFT;
    localparam int SEG_SHIFT = 20;

    // Configuration.
    logic [TICK_W-1:0] wake_ticks_reg;
    logic [TICK_W-1:0] capture_ticks_reg;
    logic [TICK_W-1:0] sleep_ticks_reg;

    // Architectural state.
    logic [1:0]          phase_reg,    phase_next;
    logic [TICK_W-1:0]   elapsed_reg,  elapsed_next;
    logic [CNT_W-1:0]    count_reg,    count_next;
    logic [SUM_W-1:0]    pm_sum_reg,   pm_sum_next;
    logic [SUM_W-1:0]    hc_sum_reg,   hc_sum_next;
    logic [PM_AVG_W-1:0] pm_avg_reg,   pm_avg_next;
    logic [HC_AVG_W-1:0] hc_avg_reg,   hc_avg_next;
    logic [AQI_W-1:0]    aqi_reg,      aqi_next;
    logic                empty_reg,    empty_next;
    logic [1:0]          scmd_reg,     scmd_next;
    logic                done_reg,     done_next;

    // Working registers for the AQI calculation.
    logic [P_W-1:0]      p_reg;
    logic [AQI_W-1:0]    base_reg;
    logic [12:0]         seg_num_reg;
    logic [18:0]         seg_mag_reg;

    // Output word.
    logic [1:0]          o_phase_reg;
    logic [1:0]          o_scmd_reg;
    logic                o_done_reg;
    logic                o_empty_reg;
    logic [PM_AVG_W-1:0] o_pm_reg;
    logic [HC_AVG_W-1:0] o_hc_reg;
    logic [AQI_W-1:0]    o_aqi_reg;
    logic [USED_W-1:0]   o_used_reg;

    logic [1:0]          ph_cur;
    logic [TICK_W-1:0]   limit;
    logic [TICK_W-1:0]   el_inc;
    logic                over;

    logic [NUM_W-1:0]    pm_num;
    logic [NUM_W-1:0]    hc_num;
    logic [DEN_W-1:0]    avg_den;
    logic                pm_div_done;
    logic                hc_div_done;
    logic [NUM_W-1:0]    pm_quot;
    logic [NUM_W-1:0]    hc_quot;

    logic [39:0]         tens_prod;
    logic [8:0]          p9;
    logic [17:0]         t18;
    logic [12:0]         seg_num;
    logic [18:0]         seg_mag;
    logic [AQI_W-1:0]    seg_base;
    logic [31:0]         seg_prod;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wake_ticks_reg    <= WAKE_TICKS_RST;
            capture_ticks_reg <= CAPTURE_TICKS_RST;
            sleep_ticks_reg   <= SLEEP_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WAKE:    wake_ticks_reg    <= cfg_data;
                REG_CAPTURE: capture_ticks_reg <= cfg_data;
                REG_SLEEP:   sleep_ticks_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Step of one accepted word
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (phase_reg)
            PH_CAPTURE: ph_cur = PH_CAPTURE;
            PH_SLEEP:   ph_cur = PH_SLEEP;
            default:    ph_cur = PH_AWAKE;
        endcase

        unique case (ph_cur)
            PH_CAPTURE: limit = capture_ticks_reg;
            PH_SLEEP:   limit = sleep_ticks_reg;
            default:    limit = wake_ticks_reg;
        endcase

        el_inc = (elapsed_reg < ELAPSED_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
        over   = (el_inc > limit);

        sts.cap_end   = (cmd == CMD_TICK) && (ph_cur == PH_CAPTURE) && over;
        sts.cap_empty = (count_reg == '0);
        sts.div_done  = pm_div_done;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        count_next   = count_reg;
        pm_sum_next  = pm_sum_reg;
        hc_sum_next  = hc_sum_reg;
        pm_avg_next  = pm_avg_reg;
        hc_avg_next  = hc_avg_reg;
        aqi_next     = aqi_reg;
        empty_next   = empty_reg;
        scmd_next    = scmd_reg;
        done_next    = done_reg;

        if (ctl.step)
        begin
            phase_next = ph_cur;
            scmd_next  = SCMD_NONE;
            done_next  = 1'b0;
            if (cmd == CMD_TICK)
            begin
                elapsed_next = over ? el_inc - limit : el_inc;
                if (over)
                begin
                    unique case (ph_cur)
                        PH_CAPTURE:
                        begin
                            phase_next = PH_SLEEP;
                            scmd_next  = SCMD_SLEEP;
                            done_next  = 1'b1;
                            // An empty capture finishes here; otherwise the
                            // dividers take over.
                            if (count_reg == '0)
                            begin
                                empty_next  = 1'b1;
                                pm_avg_next = '0;
                                hc_avg_next = '0;
                                aqi_next    = '0;
                            end
                        end
                        PH_SLEEP:
                        begin
                            phase_next = PH_AWAKE;
                            scmd_next  = SCMD_WAKE;
                        end
                        default:
                        begin
                            phase_next  = PH_CAPTURE;
                            scmd_next   = SCMD_TRIGGER;
                            count_next  = '0;
                            pm_sum_next = '0;
                            hc_sum_next = '0;
                        end
                    endcase
                end
            end
            else if ((ph_cur == PH_CAPTURE) && (count_reg < CNT_W'(MAX_SAMPLES)))
            begin
                pm_sum_next = pm_sum_reg + SUM_W'(pm25_sample);
                hc_sum_next = hc_sum_reg + SUM_W'(hcho_sample);
                count_next  = count_reg + 1'b1;
            end
        end

        if (ctl.avg_load)
        begin
            empty_next  = 1'b0;
            pm_avg_next = pm_quot[PM_AVG_W-1:0];
            hc_avg_next = hc_quot[HC_AVG_W-1:0];
        end

        if (ctl.aqi_load)
        begin
            aqi_next = base_reg + seg_prod[SEG_SHIFT +: AQI_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_AWAKE;
            elapsed_reg <= '0;
            count_reg   <= '0;
            pm_sum_reg  <= '0;
            hc_sum_reg  <= '0;
            pm_avg_reg  <= '0;
            hc_avg_reg  <= '0;
            aqi_reg     <= '0;
            empty_reg   <= 1'b1;
        end
        else
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            count_reg   <= count_next;
            pm_sum_reg  <= pm_sum_next;
            hc_sum_reg  <= hc_sum_next;
            pm_avg_reg  <= pm_avg_next;
            hc_avg_reg  <= hc_avg_next;
            aqi_reg     <= aqi_next;
            empty_reg   <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scmd_reg <= scmd_next;
        done_reg <= done_next;
    end

    // ------------------------------------------------------------------
    // Averages: (20*sum + n) / 2n and (2*sum + n) / 2n round half up.
    // ------------------------------------------------------------------
    always_comb
    begin
        pm_num  = (NUM_W'(pm_sum_reg) << 4) + (NUM_W'(pm_sum_reg) << 2) + NUM_W'(count_reg);
        hc_num  = (NUM_W'(hc_sum_reg) << 1) + NUM_W'(count_reg);
        avg_den = DEN_W'({count_reg, 1'b0});
    end

    pmdca_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_pm_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   (pm_num),
        .den   (avg_den),
        .done  (pm_div_done),
        .quot  (pm_quot)
    );

    pmdca_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_hc_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   (hc_num),
        .den   (avg_den),
        .done  (hc_div_done),
        .quot  (hc_quot)
    );

    // ------------------------------------------------------------------
    // AQI: integer micrograms, then the segment slope as a reciprocal
    // multiplication scaled by 2^20.
    // ------------------------------------------------------------------
    assign tens_prod = 40'(pm_avg_reg) * 40'(DIV10_MAGIC);
    assign seg_prod  = 32'(seg_num_reg) * 32'(seg_mag_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.tens_load)
        begin
            p_reg <= tens_prod[39:DIV10_SHIFT];
        end
        if (ctl.aqi_start)
        begin
            base_reg    <= seg_base;
            seg_num_reg <= seg_num;
            seg_mag_reg <= seg_mag;
        end
    end

    // Each slope is reduced to a small divisor whose rounded-up reciprocal
    // gives the truncated quotient exactly over the whole segment.
    always_comb
    begin
        p9  = p_reg[8:0];
        t18 = 18'(p9) * 18'd10;

        // Breakpoints of the EPA table, compared in whole micrograms; the segment offsets are in tenths.
        if (p_reg <= P_W'(12))
        begin
            seg_num  = 13'(p9) * 13'd25;
            seg_mag  = 19'd174763;
            seg_base = 9'd0;
        end
        else if (p_reg <= P_W'(35))
        begin
            seg_num  = (13'(p9) - 13'd12) * 13'd250;
            seg_mag  = 19'd8963;
            seg_base = 9'd50;
        end
        else if (p_reg <= P_W'(55))
        begin
            seg_num  = 13'(t18 - 18'd354);
            seg_mag  = 19'd262144;
            seg_base = 9'd100;
        end
        else if (p_reg <= P_W'(150))
        begin
            seg_num  = 13'(t18 - 18'd554);
            seg_mag  = 19'd55189;
            seg_base = 9'd150;
        end
        else if (p_reg <= P_W'(250))
        begin
            seg_num  = 13'(t18 - 18'd1504);
            seg_mag  = 19'd104858;
            seg_base = 9'd200;
        end
        else if (p_reg <= P_W'(350))
        begin
            seg_num  = 13'(t18 - 18'd2504);
            seg_mag  = 19'd104858;
            seg_base = 9'd300;
        end
        else if (p_reg <= P_W'(500))
        begin
            seg_num  = 13'(t18 - 18'd3504);
            seg_mag  = 19'd69906;
            seg_base = 9'd400;
        end
        else
        begin
            seg_num  = 13'd0;
            seg_mag  = 19'd0;
            seg_base = 9'd500;
        end
    end

    // ------------------------------------------------------------------
    // Output word register
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            o_phase_reg <= phase_reg;
            o_scmd_reg  <= scmd_reg;
            o_done_reg  <= done_reg;
            o_empty_reg <= empty_reg;
            o_pm_reg    <= pm_avg_reg;
            o_hc_reg    <= hc_avg_reg;
            o_aqi_reg   <= aqi_reg;
            o_used_reg  <= USED_W'(count_reg);
        end
    end

    assign phase        = o_phase_reg;
    assign sensor_cmd   = o_scmd_reg;
    assign reading_done = o_done_reg;
    assign no_data      = o_empty_reg;
    assign pm25_tenths  = o_pm_reg;
    assign hcho_average = o_hc_reg;
    assign aqi          = o_aqi_reg;
    assign samples_used = o_used_reg;

    `PMDCA_ASSERT(a_div_lockstep, clk, rst_n, hc_div_done |-> pm_div_done, "dividers out of step")
    `PMDCA_ASSERT(a_count_cap, clk, rst_n, count_reg <= CNT_W'(MAX_SAMPLES), "sample count overrun")

endmodule

`default_nettype wire

// File: rtl/pmdca_ctrl.sv
// ----------------------------------------------------------------------------
// pmdca_ctrl
// Sequencer: takes a word, averages when a capture ends, hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pmdca_ctrl
    import pmdca_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire pmdca_sts_t sts,
    output pmdca_cmd_t      ctl
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_AVG  = 6'b000010,
        S_TENS = 6'b000100,
        S_SEG  = 6'b001000,
        S_AQI  = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.step = 1'b1;
                    if (sts.cap_end && !sts.cap_empty)
                    begin
                        ctl.div_start = 1'b1;
                        state_next    = S_AVG;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_AVG:
            begin
                if (sts.div_done)
                begin
                    ctl.avg_load = 1'b1;
                    state_next   = S_TENS;
                end
            end
            S_TENS:
            begin
                ctl.tens_load = 1'b1;
                state_next    = S_SEG;
            end
            S_SEG:
            begin
                ctl.aqi_start = 1'b1;
                state_next    = S_AQI;
            end
            S_AQI:
            begin
                ctl.aqi_load = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                // The output register frees in the same cycle it is taken.
                if (!out_valid_reg || !out_stall)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    `PMDCA_ASSERT(a_out_from_emit, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == S_EMIT), "result word raised outside emit")
    `PMDCA_ASSERT(a_done_when_waiting, clk, rst_n, sts.div_done |-> (state_reg == S_AVG), "divider finished unexpectedly")

endmodule

`default_nettype wire

// File: rtl/pm_sensor_duty_cycle_averager.sv
// An accepted tick or sample word goes through the emit state to the output word
// register and waits there while the receiver stalls; a tick that ends a capture
// with samples first runs the one-bit-per-cycle divider and the tens, segment and
// AQI steps. No new word is taken before the last is loaded. Reset (rst_n low,
// asynchronous): tick limits return to 15000/5000/70000, all timing and averaging
// state clears, the empty flag behind no_data is set and no result is pending.
// ----------------------------------------------------------------------------
// pm_sensor_duty_cycle_averager
// Duty cycles a particle sensor and reports PM2.5, HCHO averages and AQI.
// ----------------------------------------------------------------------------
`default_nettype none

module pm_sensor_duty_cycle_averager
    import pmdca_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]    cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 cmd,
    input  wire logic [SAMPLE_W-1:0]  pm25_sample,
    input  wire logic [SAMPLE_W-1:0]  hcho_sample,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [1:0]                phase,
    output logic [1:0]                sensor_cmd,
    output logic                      reading_done,
    output logic                      no_data,
    output logic [PM_AVG_W-1:0]       pm25_tenths,
    output logic [HC_AVG_W-1:0]       hcho_average,
    output logic [AQI_W-1:0]          aqi,
    output logic [USED_W-1:0]         samples_used
);

    pmdca_cmd_t ctl;
    pmdca_sts_t sts;

    pmdca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    pmdca_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .pm25_sample  (pm25_sample),
        .hcho_sample  (hcho_sample),
        .ctl          (ctl),
        .sts          (sts),
        .phase        (phase),
        .sensor_cmd   (sensor_cmd),
        .reading_done (reading_done),
        .no_data      (no_data),
        .pm25_tenths  (pm25_tenths),
        .hcho_average (hcho_average),
        .aqi          (aqi),
        .samples_used (samples_used)
    );

endmodule

`default_nettype wire

// File: test/pmdca_reading_checker.sv
// ----------------------------------------------------------------------------
// pmdca_reading_checker
// Watches the configuration port and both word channels of the duty cycle
// averager, predicts every result word from the accepted input words and
// compares each result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pmdca_reading_checker
    import pmdca_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]    cfg_data,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic                 cmd,
    input  wire logic [SAMPLE_W-1:0]  pm25_sample,
    input  wire logic [SAMPLE_W-1:0]  hcho_sample,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire logic [1:0]           phase,
    input  wire logic [1:0]           sensor_cmd,
    input  wire logic                 reading_done,
    input  wire logic                 no_data,
    input  wire logic [PM_AVG_W-1:0]  pm25_tenths,
    input  wire logic [HC_AVG_W-1:0]  hcho_average,
    input  wire logic [AQI_W-1:0]     aqi,
    input  wire logic [USED_W-1:0]    samples_used,
    output int                        fail_count,
    output int                        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]          phase;
        logic [1:0]          sensor_cmd;
        logic                reading_done;
        logic                no_data;
        logic [PM_AVG_W-1:0] pm25_tenths;
        logic [HC_AVG_W-1:0] hcho_average;
        logic [AQI_W-1:0]    aqi;
        logic [USED_W-1:0]   samples_used;
    } reading_t;

    logic [TICK_W-1:0]   wake_limit;
    logic [TICK_W-1:0]   capture_limit;
    logic [TICK_W-1:0]   sleep_limit;
    logic [1:0]          phase_now;
    logic [TICK_W-1:0]   elapsed_ticks;
    logic [USED_W-1:0]   sample_count;
    longint unsigned     pm_total;
    longint unsigned     hcho_total;
    logic [PM_AVG_W-1:0] pm_mean;
    logic [HC_AVG_W-1:0] hcho_mean;
    logic [AQI_W-1:0]    aqi_now;
    logic                empty_capture;
    reading_t            expected_readings[$];
    int                  word_no = 0;
    int                  fails = 0;

    // US EPA breakpoints, worked in tenths of a microgram with truncation.
    function automatic int unsigned epa_index(int unsigned p);
        int unsigned t;
        t = p * 10;
        if (p <= 12) return (50 * p) / 12;
        if (p <= 35) return 50 + (500 * (p - 12)) / 234;
        if (p <= 55) return 100 + (t - 354) / 4;
        if (p <= 150) return 150 + (50 * (t - 554)) / 950;
        if (p <= 250) return 200 + (t - 1504) / 10;
        if (p <= 350) return 300 + (t - 2504) / 10;
        if (p <= 500) return 400 + (100 * (t - 3504)) / 1500;
        return 500;
    endfunction

    function automatic void close_capture();
        longint unsigned c;
        longint unsigned pm_q;
        longint unsigned hc_q;
        if (sample_count == 0) begin
            empty_capture = 1'b1;
            pm_mean = '0;
            hcho_mean = '0;
            aqi_now = '0;
        end
        else begin
            c = sample_count;
            // Both means round half up: add half the divisor before dividing.
            pm_q = (pm_total * 20 + c) / (2 * c);
            hc_q = (hcho_total * 2 + c) / (2 * c);
            empty_capture = 1'b0;
            pm_mean = pm_q[PM_AVG_W-1:0];
            hcho_mean = hc_q[HC_AVG_W-1:0];
            aqi_now = AQI_W'(epa_index(32'(pm_mean) / 10));
        end
    endfunction

    function automatic reading_t step_sensor(logic kind, logic [SAMPLE_W-1:0] pm,
                                             logic [SAMPLE_W-1:0] hc);
        reading_t          r;
        logic [TICK_W-1:0] limit;
        r = '0;
        if (kind == CMD_TICK) begin
            if (phase_now == PH_CAPTURE) limit = capture_limit;
            else if (phase_now == PH_SLEEP) limit = sleep_limit;
            else limit = wake_limit;
            if (elapsed_ticks != ELAPSED_MAX) elapsed_ticks = elapsed_ticks + 1'b1;
            if (elapsed_ticks > limit) begin
                elapsed_ticks = elapsed_ticks - limit;
                if (phase_now == PH_CAPTURE) begin
                    phase_now = PH_SLEEP;
                    r.sensor_cmd = SCMD_SLEEP;
                    r.reading_done = 1'b1;
                    close_capture();
                end
                else if (phase_now == PH_SLEEP) begin
                    phase_now = PH_AWAKE;
                    r.sensor_cmd = SCMD_WAKE;
                end
                else begin
                    phase_now = PH_CAPTURE;
                    r.sensor_cmd = SCMD_TRIGGER;
                    sample_count = '0;
                    pm_total = 0;
                    hcho_total = 0;
                end
            end
        end
        else if (phase_now == PH_CAPTURE && sample_count < MAX_SAMPLES_DEF) begin
            pm_total = pm_total + pm;
            hcho_total = hcho_total + hc;
            sample_count = sample_count + 1'b1;
        end
        r.phase = phase_now;
        r.no_data = empty_capture;
        r.pm25_tenths = pm_mean;
        r.hcho_average = hcho_mean;
        r.aqi = aqi_now;
        r.samples_used = sample_count;
        return r;
    endfunction

    task automatic report(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        fails++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report($sformatf("result word %0d: %s is %0d, expected %0d",
                             word_no, name, got, want));
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        reading_t want;
        if (!rst_n) begin
            wake_limit = WAKE_TICKS_RST;
            capture_limit = CAPTURE_TICKS_RST;
            sleep_limit = SLEEP_TICKS_RST;
            phase_now = PH_AWAKE;
            elapsed_ticks = '0;
            sample_count = '0;
            pm_total = 0;
            hcho_total = 0;
            pm_mean = '0;
            hcho_mean = '0;
            aqi_now = '0;
            empty_capture = 1'b1;
            expected_readings.delete();
            outstanding <= 0;
            fail_count <= fails;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_WAKE:    wake_limit = cfg_data;
                    REG_CAPTURE: capture_limit = cfg_data;
                    REG_SLEEP:   sleep_limit = cfg_data;
                    default:     ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (expected_readings.size() == 0) begin
                    report($sformatf("result word %0d arrived with nothing expected",
                                     word_no));
                end
                else begin
                    want = expected_readings.pop_front();
                    check_field("phase", phase, want.phase);
                    check_field("sensor_cmd", sensor_cmd, want.sensor_cmd);
                    check_field("reading_done", reading_done, want.reading_done);
                    check_field("no_data", no_data, want.no_data);
                    check_field("pm25_tenths", pm25_tenths, want.pm25_tenths);
                    check_field("hcho_average", hcho_average, want.hcho_average);
                    check_field("aqi", aqi, want.aqi);
                    check_field("samples_used", samples_used, want.samples_used);
                end
                word_no++;
            end
            if (in_valid && !in_stall)
                expected_readings.push_back(step_sensor(cmd, pm25_sample, hcho_sample));
            outstanding <= expected_readings.size();
            fail_count <= fails;
        end
    end

endmodule

// File: test/pm_sensor_duty_cycle_averager_tb.sv
// ----------------------------------------------------------------------------
// pm_sensor_duty_cycle_averager_tb
// Drives ticks and sensor samples into the duty cycle averager under several
// tick limit settings, with bursty input and a stalling receiver, and leaves
// prediction and comparison to the reading checker.
// ----------------------------------------------------------------------------
module pm_sensor_duty_cycle_averager_tb
    import pmdca_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_WORDS   = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 100;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TICK_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 cmd;
    logic [SAMPLE_W-1:0]  pm25_sample;
    logic [SAMPLE_W-1:0]  hcho_sample;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           phase;
    logic [1:0]           sensor_cmd;
    logic                 reading_done;
    logic                 no_data;
    logic [PM_AVG_W-1:0]  pm25_tenths;
    logic [HC_AVG_W-1:0]  hcho_average;
    logic [AQI_W-1:0]     aqi;
    logic [USED_W-1:0]    samples_used;

    int fail_count;
    int outstanding;
    int burst_left = 0;
    bit steady = 1'b0;
    int sample_pct = 50;
    int words_sent = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int idle_cycles;

    always #(CLK_PERIOD / 2) clk = ~clk;

    pm_sensor_duty_cycle_averager DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .pm25_sample  (pm25_sample),
        .hcho_sample  (hcho_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .phase        (phase),
        .sensor_cmd   (sensor_cmd),
        .reading_done (reading_done),
        .no_data      (no_data),
        .pm25_tenths  (pm25_tenths),
        .hcho_average (hcho_average),
        .aqi          (aqi),
        .samples_used (samples_used)
    );

    pmdca_reading_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .pm25_sample  (pm25_sample),
        .hcho_sample  (hcho_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .phase        (phase),
        .sensor_cmd   (sensor_cmd),
        .reading_done (reading_done),
        .no_data      (no_data),
        .pm25_tenths  (pm25_tenths),
        .hcho_average (hcho_average),
        .aqi          (aqi),
        .samples_used (samples_used),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // The receiver switches between free running, light and heavy stalling.
    always @(negedge clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_word(logic kind, logic [SAMPLE_W-1:0] pm, logic [SAMPLE_W-1:0] hc);
        if (burst_left == 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge clk);
            burst_left = steady ? 1000 : $urandom_range(1, 30);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        cmd <= kind;
        pm25_sample <= pm;
        hcho_sample <= hc;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        words_sent++;
    endtask

    task automatic stop_traffic();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_idle();
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly short limits so that all three phases come round often.
    function automatic logic [TICK_W-1:0] pick_limit();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 20'd1;
            2:       return 20'd1000000;
            3:       return TICK_W'($urandom_range(1, 1000000));
            default: return TICK_W'($urandom_range(1, 12));
        endcase
    endfunction

    // Readings mostly fall within the AQI breakpoint range, with some over the full range.
    function automatic logic [SAMPLE_W-1:0] sample_value();
        case ($urandom_range(0, 4))
            0, 1:    return SAMPLE_W'($urandom_range(0, 600));
            2:       return SAMPLE_W'($urandom_range(0, 60));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial begin
        int n;
        int phase_no;
        logic kind;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_WAKE;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = CMD_TICK;
        pm25_sample = '0;
        hcho_sample = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Reset limits: a tick, then a sample that arrives while awake.
        send_word(CMD_TICK, 16'hFFFF, 16'hFFFF);
        send_word(CMD_SAMPLE, 16'hFFFF, 16'hFFFF);
        stop_traffic();
        wait_idle();

        // A zero wake limit ends the awake phase on the very next tick.
        write_reg(REG_WAKE, '0);
        write_reg(REG_CAPTURE, 20'd3);
        write_reg(REG_SLEEP, 20'd1);
        send_word(CMD_TICK, '0, '0);
        send_word(CMD_SAMPLE, '0, '0);
        send_word(CMD_SAMPLE, 16'hFFFF, 16'hFFFF);
        send_word(CMD_SAMPLE, 16'd1, 16'd1);
        send_word(CMD_TICK, '0, '0);
        send_word(CMD_TICK, '0, '0);
        send_word(CMD_TICK, '0, '0);
        send_word(CMD_SAMPLE, 16'd100, 16'd100);
        send_word(CMD_TICK, '0, '0);
        send_word(CMD_TICK, '0, '0);
        // A capture made of ticks alone reports no data.
        repeat (6) send_word(CMD_TICK, 16'hFFFF, '0);
        stop_traffic();
        wait_idle();

        write_reg(REG_WAKE, 20'd1000000);
        send_word(CMD_TICK, '0, 16'hFFFF);
        send_word(CMD_SAMPLE, 16'd55, 16'd55);
        send_word(CMD_TICK, '0, '0);
        stop_traffic();
        wait_idle();

        words_sent = 0;
        phase_no = 0;
        while (words_sent < RANDOM_WORDS) begin
            if (phase_no == 0 || $urandom_range(0, 2) == 0) write_reg(REG_WAKE, pick_limit());
            if (phase_no == 0 || $urandom_range(0, 2) == 0) write_reg(REG_CAPTURE, pick_limit());
            if (phase_no == 0 || $urandom_range(0, 2) == 0) write_reg(REG_SLEEP, pick_limit());
            sample_pct = $urandom_range(0, 90);
            steady = ($urandom_range(0, 3) == 0);
            n = $urandom_range(20, 60);
            repeat (n) begin
                kind = ($urandom_range(0, 99) < sample_pct) ? CMD_SAMPLE : CMD_TICK;
                send_word(kind, sample_value(), sample_value());
            end
            stop_traffic();
            wait_idle();
            phase_no++;
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/pmdca_pkg.sv
rtl/pmdca_divider.sv
rtl/pmdca_datapath.sv
rtl/pmdca_ctrl.sv
rtl/pm_sensor_duty_cycle_averager.sv
test/pmdca_reading_checker.sv
test/pm_sensor_duty_cycle_averager_tb.sv
